@@ rtl/rgme_pkg.sv @@
// package for the relation graph matrix engine
// sequencer states, item mode codes, register indexes and the store control group
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rgme_pkg;

	localparam logic [2:0] MODE_CLEAR  = 3'd0;
	localparam logic [2:0] MODE_ADD    = 3'd1;
	localparam logic [2:0] MODE_REMOVE = 3'd2;
	localparam logic [2:0] MODE_DIRECT = 3'd3;
	localparam logic [2:0] MODE_REACH  = 3'd4;
	localparam logic [2:0] MODE_CYCLE  = 3'd5;

	localparam logic [1:0] CFG_SYMMETRIC  = 2'd0;
	localparam logic [1:0] CFG_REFLEXIVE  = 2'd1;
	localparam logic [1:0] CFG_TRANSITIVE = 2'd2;
	localparam logic [1:0] CFG_NODE_COUNT = 2'd3;

	localparam logic [4:0] NODE_COUNT_RESET = 5'd16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_F,
		ST_GET_F,
		ST_GET_T,
		ST_WR_F,
		ST_REACH_PICK,
		ST_REACH_GET,
		ST_CYC_RD,
		ST_CYC_GET,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
		logic clr_refl;
	} store_ctl_t;

endpackage
`default_nettype wire

@@ rtl/rgme_store.sv @@
// adjacency row store: one row memory, row valid bits and the cleared-row image
// depends on rgme_pkg for the control group
`timescale 1ns / 1ps
`default_nettype none
module rgme_store #(
	parameter int ROWS = 16,
	parameter int IW   = 4,
	parameter int NW   = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rgme_pkg::store_ctl_t ctl,
	input  wire logic [NW-1:0]        clr_n,
	input  wire logic [IW-1:0]        rd_addr,
	input  wire logic [IW-1:0]        wr_addr,
	input  wire logic [ROWS-1:0]      wr_data,
	output logic      [ROWS-1:0]      rd_row
);
	import rgme_pkg::*;

	logic [ROWS-1:0] mem [ROWS];
	logic [ROWS-1:0] vld_q;
	logic [ROWS-1:0] rd_data_q;
	logic            rd_vld_q;
	logic [IW-1:0]   rd_addr_q;
	logic            diag_q;
	logic [NW-1:0]   diag_n_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_addr_q <= '0;
			diag_q    <= 1'b0;
			diag_n_q  <= '0;
		end else begin
			if (ctl.clr) begin
				vld_q    <= '0;
				diag_q   <= ctl.clr_refl;
				diag_n_q <= clr_n;
			end else if (ctl.wr) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_vld_q  <= vld_q[rd_addr];
				rd_addr_q <= rd_addr;
			end
		end
	end

	// a row not written since the last clear reads as its cleared image
	always_comb begin
		if (rd_vld_q) begin
			rd_row = rd_data_q;
		end else if (diag_q && (32'(rd_addr_q) < 32'(diag_n_q))) begin
			rd_row = ROWS'(1) << rd_addr_q;
		end else begin
			rd_row = '0;
		end
	end

endmodule
`default_nettype wire

@@ rtl/relation_graph_matrix_engine.sv @@
// Relation graph engine: a directed adjacency bit matrix of MAX_NODES rows, one row
// per node, read and written one row per cycle through a row memory with one read
// port and one write port, under a small sequencer. One item is taken at a time and
// in_stall stays high until its result is placed in the output register; the next
// item may be taken while that result still waits. Clear drops the row valid bits as
// it is taken. A reachable test reads the source row and then the row of each node
// reached. A cycle test makes passes over the n nodes in use and ends after the first
// pass that removes no sink or leaves no node, so at most n passes. No clearing pass
// follows reset.
// depends on rgme_pkg and rgme_store
`timescale 1ns / 1ps
`default_nettype none
module relation_graph_matrix_engine #(
	parameter int MAX_NODES = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_index,
	input  wire logic [4:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] mode,
	input  wire logic [3:0] from_node,
	input  wire logic [3:0] to_node,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            answer,
	output logic            bad_node
);
	import rgme_pkg::*;

	localparam int RW = MAX_NODES;
	localparam int IW = $clog2(MAX_NODES);
	localparam int NW = $clog2(MAX_NODES + 1);

	logic          symmetric_q;
	logic          reflexive_q;
	logic          transitive_q;
	logic [4:0]    node_count_q;

	state_t        state_q;
	state_t        state_d;
	logic [2:0]    mode_q;
	logic [IW-1:0] f_q;
	logic [IW-1:0] t_q;
	logic [RW-1:0] row_q;
	logic [RW-1:0] visited_q;
	logic [RW-1:0] done_q;
	logic [RW-1:0] removed_q;
	logic [NW-1:0] idx_q;
	logic          rem_any_q;
	logic          ans_q;
	logic          bad_q;
	logic          out_valid_q;
	logic          answer_q;
	logic          bad_node_q;

	logic [NW-1:0] n;
	logic [RW-1:0] mask;
	logic [RW-1:0] live;
	logic [RW-1:0] pend;
	logic [IW-1:0] pick;
	logic          acc;
	logic          bad_in;
	logic          self_in;
	logic          out_free;

	logic [RW-1:0] bit_f;
	logic [RW-1:0] bit_t;
	logic [RW-1:0] bit_idx;
	logic          same;
	logic [RW-1:0] fa;
	logic [RW-1:0] tv;
	logic [RW-1:0] fv;
	logic [RW-1:0] clr_bits;

	store_ctl_t    ctl;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic [RW-1:0] wr_data;
	logic [RW-1:0] rd_row;

	rgme_store #(
		.ROWS(RW),
		.IW  (IW),
		.NW  (NW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.clr_n  (n),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_row (rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symmetric_q  <= 1'b0;
			reflexive_q  <= 1'b0;
			transitive_q <= 1'b0;
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SYMMETRIC:  symmetric_q  <= cfg_data[0];
				CFG_REFLEXIVE:  reflexive_q  <= cfg_data[0];
				CFG_TRANSITIVE: transitive_q <= cfg_data[0];
				CFG_NODE_COUNT: node_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// node count saturated to 1..MAX_NODES
	always_comb begin
		if (node_count_q == 5'd0) begin
			n = NW'(1);
		end else if (32'(node_count_q) > MAX_NODES) begin
			n = NW'(MAX_NODES);
		end else begin
			n = NW'(node_count_q);
		end
	end

	always_comb begin
		for (int i = 0; i < RW; i++) begin
			mask[i] = (i < 32'(n));
		end
	end

	assign live = mask & ~removed_q;
	assign pend = visited_q & ~done_q;

	// lowest pending node
	always_comb begin
		pick = '0;
		for (int i = RW - 1; i >= 0; i--) begin
			if (pend[i]) begin
				pick = IW'(i);
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign bad_in   = ((mode == MODE_ADD) || (mode == MODE_REMOVE) ||
		(mode == MODE_DIRECT) || (mode == MODE_REACH)) &&
		((32'(from_node) >= 32'(n)) || (32'(to_node) >= 32'(n)));
	assign self_in  = reflexive_q && (from_node == to_node);

	assign bit_f   = RW'(1) << f_q;
	assign bit_t   = RW'(1) << t_q;
	assign bit_idx = RW'(1) << idx_q[IW-1:0];
	assign same    = (f_q == t_q);

	// edge update: row_q holds the source row, rd_row the target row
	always_comb begin
		clr_bits = '0;
		if (mode_q == MODE_ADD) begin
			fa = row_q | bit_t;
			tv = (same ? fa : rd_row) | (symmetric_q ? bit_f : '0);
			fv = (same ? tv : fa) | (transitive_q ? (tv & mask) : '0);
		end else begin
			fa       = row_q & ~bit_t;
			tv       = (same ? fa : rd_row) & ~(symmetric_q ? bit_f : '0);
			clr_bits = tv & mask & ~(reflexive_q ? bit_f : '0);
			fv       = (same ? tv : fa) & ~(transitive_q ? clr_bits : '0);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (bad_in) begin
						state_d = ST_DONE;
					end else begin
						case (mode)
							MODE_ADD, MODE_DIRECT, MODE_REACH: state_d = ST_RD_F;
							MODE_REMOVE: state_d = self_in ? ST_DONE : ST_RD_F;
							MODE_CYCLE:  state_d = ST_CYC_RD;
							default:     state_d = ST_DONE;
						endcase
					end
				end
			end
			ST_RD_F: state_d = ST_GET_F;
			ST_GET_F: begin
				case (mode_q)
					MODE_DIRECT: state_d = ST_DONE;
					MODE_REACH:  state_d = ST_REACH_PICK;
					default:     state_d = ST_GET_T;
				endcase
			end
			ST_GET_T: state_d = ST_WR_F;
			ST_WR_F:  state_d = ST_DONE;
			ST_REACH_PICK: state_d = (pend == '0) ? ST_DONE : ST_REACH_GET;
			ST_REACH_GET:  state_d = ST_REACH_PICK;
			ST_CYC_RD: begin
				if (idx_q != n) begin
					state_d = ST_CYC_GET;
				end else if ((live == '0) || !rem_any_q) begin
					state_d = ST_DONE;
				end
			end
			ST_CYC_GET: state_d = ST_CYC_RD;
			ST_DONE: state_d = out_free ? ST_IDLE : ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	// store control
	always_comb begin
		ctl          = '0;
		ctl.clr_refl = reflexive_q;
		rd_addr      = f_q;
		wr_addr      = f_q;
		wr_data      = row_q;
		unique case (state_q)
			ST_IDLE: begin
				ctl.clr = acc && (mode == MODE_CLEAR);
			end
			ST_RD_F: begin
				ctl.rd = 1'b1;
			end
			ST_GET_F: begin
				ctl.rd  = (mode_q == MODE_ADD) || (mode_q == MODE_REMOVE);
				rd_addr = t_q;
			end
			ST_GET_T: begin
				ctl.wr  = 1'b1;
				wr_addr = t_q;
				wr_data = tv;
			end
			ST_WR_F: begin
				ctl.wr = 1'b1;
			end
			ST_REACH_PICK: begin
				ctl.rd  = (pend != '0);
				rd_addr = pick;
			end
			ST_CYC_RD: begin
				ctl.rd  = (idx_q != n);
				rd_addr = idx_q[IW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			visited_q   <= '0;
			removed_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_GET_F && mode_q == MODE_REACH) begin
				visited_q <= rd_row & mask;
			end else if (state_q == ST_REACH_GET) begin
				visited_q <= visited_q | (rd_row & mask);
			end
			if (state_q == ST_IDLE && acc) begin
				removed_q <= '0;
			end else if (state_q == ST_CYC_GET && live[idx_q[IW-1:0]] &&
				((rd_row & live) == '0)) begin
				removed_q <= removed_q | bit_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					mode_q    <= mode;
					f_q       <= IW'(from_node);
					t_q       <= IW'(to_node);
					ans_q     <= 1'b0;
					bad_q     <= bad_in;
					idx_q     <= '0;
					rem_any_q <= 1'b0;
					done_q    <= '0;
				end
			end
			ST_GET_F: begin
				row_q <= rd_row;
				if (mode_q == MODE_DIRECT) begin
					ans_q <= rd_row[t_q];
				end
			end
			ST_GET_T: begin
				row_q <= fv;
			end
			ST_REACH_PICK: begin
				if (pend == '0) begin
					ans_q <= visited_q[t_q];
				end else begin
					done_q <= done_q | (RW'(1) << pick);
				end
			end
			ST_CYC_RD: begin
				if (idx_q == n) begin
					ans_q     <= (live != '0);
					idx_q     <= '0;
					rem_any_q <= 1'b0;
				end
			end
			ST_CYC_GET: begin
				if (live[idx_q[IW-1:0]] && ((rd_row & live) == '0)) begin
					rem_any_q <= 1'b1;
				end
				idx_q <= idx_q + NW'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					answer_q   <= ans_q;
					bad_node_q <= bad_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign answer    = answer_q;
	assign bad_node  = bad_node_q;

endmodule
`default_nettype wire
